FILE: design/gpsp_pkg.sv
// Shared types, codes and set-up frame tables for the serial controller poller.
// No dependencies; used by gpsp_cmd_rom and gamepad_serial_poll_with_config.
package gpsp_pkg;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_SLOT  = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    KIND_QUERY  = 3'd0,
    KIND_SETUP1 = 3'd1,
    KIND_SETUP2 = 3'd2,
    KIND_SETUP3 = 3'd3,
    KIND_SETUP4 = 3'd4,
    KIND_SETUP5 = 3'd5,
    KIND_REPEAT = 3'd6
  } kind_t;

  localparam logic [7:0] CMD_START  = 8'h01;
  localparam logic [7:0] CMD_POLL   = 8'h42;
  localparam logic [7:0] CMD_CONFIG = 8'h43;
  localparam logic [7:0] CMD_MODE   = 8'h44;
  localparam logic [7:0] CMD_MOTOR  = 8'h4D;
  localparam logic [7:0] CMD_PRESS  = 8'h4F;
  localparam logic [7:0] BYTE_NONE  = 8'hFF;
  localparam logic [7:0] BYTE_MASK  = 8'h03;

  localparam logic [4:0] POLL_LEN_RESET = 5'd21;
  localparam logic [5:0] POLL_LEN_MIN   = 6'd2;

  // Bytes in each set-up frame (kinds 1..5).
  function automatic logic [3:0] setup_len(input logic [2:0] kind);
    logic [3:0] n;
    unique case (kind)
      KIND_SETUP1: n = 4'd5;
      KIND_SETUP5: n = 4'd8;
      default:     n = 4'd9;
    endcase
    return n;
  endfunction

  // Command byte of a set-up frame at a given position; zero past the end.
  function automatic logic [7:0] setup_byte(input logic [2:0] kind, input logic [4:0] pos);
    logic [7:0] b;
    b = 8'h00;
    if (pos == 5'd0) begin
      b = CMD_START;
    end else if (pos == 5'd1) begin
      unique case (kind)
        KIND_SETUP2: b = CMD_MODE;
        KIND_SETUP3: b = CMD_MOTOR;
        KIND_SETUP4: b = CMD_PRESS;
        default:     b = CMD_CONFIG;
      endcase
    end else begin
      unique case (kind)
        KIND_SETUP1: b = (pos == 5'd3) ? CMD_START : 8'h00;
        KIND_SETUP2: begin
          if (pos == 5'd3) b = CMD_START;
          else if (pos == 5'd4) b = BYTE_MASK;
        end
        KIND_SETUP3: begin
          if (pos == 5'd4) b = CMD_START;
          else if (pos >= 5'd5 && pos <= 5'd8) b = BYTE_NONE;
        end
        KIND_SETUP4: begin
          if (pos == 5'd3 || pos == 5'd4) b = BYTE_NONE;
          else if (pos == 5'd5) b = BYTE_MASK;
        end
        KIND_SETUP5: begin
          if (pos >= 5'd4 && pos <= 5'd7) b = BYTE_NONE;
        end
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

FILE: design/gpsp_cmd_rom.sv
// Command byte lookup: query frames from the motor latches, set-up frames from table.
// Depends on gpsp_pkg.
module gpsp_cmd_rom (
  input  logic [2:0] kind,
  input  logic [4:0] pos,
  input  logic [7:0] small_motor,
  input  logic [7:0] large_motor,
  output logic [7:0] cmd_byte
);

  always_comb begin
    if (kind >= gpsp_pkg::KIND_SETUP1 && kind <= gpsp_pkg::KIND_SETUP5) begin
      cmd_byte = gpsp_pkg::setup_byte(kind, pos);
    end else begin
      unique case (pos)
        5'd0:    cmd_byte = gpsp_pkg::CMD_START;
        5'd1:    cmd_byte = gpsp_pkg::CMD_POLL;
        5'd3:    cmd_byte = small_motor;
        5'd4:    cmd_byte = large_motor;
        default: cmd_byte = 8'h00;
      endcase
    end
  end

endmodule

FILE: design/gamepad_serial_poll_with_config.sv
// Top level of the serial controller poll sequencer.
// Depends on gpsp_pkg and gpsp_cmd_rom.
//
// Usage:
//   s_axis carries one request per transaction: tuser selects a start request
//   (latches the two motor bytes, begins the query frame) or one bit slot with
//   the sampled data line. m_axis returns exactly one result per request: the
//   command level for the next slot, attention, a completed response byte with
//   its frame kind (tuser) and position, and the end-of-sequence flag/status.
//   cfg writes the query length; cfg_ready is always high, write only while idle.
// Timing:
//   One request per cycle sustained unless m_axis stalls. A result appears in the
//   output register in the cycle after its request is taken. The sequencer state
//   and the result register are updated by one pass through the command byte lookup.
// Reset:
//   rst clears the sequencer (idle, unconfigured), the output valid, and sets
//   the query length to 21.
// Stall:
//   While a result waits with m_axis_tready low, s_axis_tready drops; no
//   request is lost and no result is repeated.
module gamepad_serial_poll_with_config #(
  parameter int unsigned MAX_POLL_BYTES = 21
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] small motor, [15:8] large motor, [16] data_bit
  input  logic        s_axis_tuser,  // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [0] cmd_bit, [1] attention, [2] byte_valid,
                                     // [10:3] rx_byte, [15:11] byte_index,
                                     // [16] done_res, [17] status
  output logic [2:0]  m_axis_tuser,  // [2:0] frame_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data       // [4:0] poll_length
);

  localparam logic [5:0] MaxLen = 6'(MAX_POLL_BYTES);

  logic [4:0] poll_length;
  logic       configured, configured_next;
  logic [2:0] frame_number, frame_number_next;
  logic [4:0] byte_position, byte_position_next;
  logic [2:0] bit_position, bit_position_next;
  logic [7:0] rx_shift, rx_shift_next;
  logic       active, active_next;
  logic [7:0] small_motor_latch, small_next;
  logic [7:0] large_motor_latch, large_next;

  logic [23:0] res_data, res_data_next;
  logic [2:0]  res_kind, res_kind_next;
  logic        res_valid;

  logic       take;
  logic [5:0] query_len, frame_len;
  logic [7:0] got;
  logic [7:0] cmd_byte;
  logic       valid_o, done_o, status_o, cmd_o;
  logic [7:0] rx_o;
  logic [2:0] kind_o;
  logic [4:0] idx_o;

  assign s_axis_tready = !res_valid || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = res_data;
  assign m_axis_tuser  = res_kind;

  always_comb begin
    query_len = {1'b0, poll_length};
    if (query_len < gpsp_pkg::POLL_LEN_MIN) query_len = gpsp_pkg::POLL_LEN_MIN;
    if (query_len > MaxLen) query_len = MaxLen;
    if (frame_number >= gpsp_pkg::KIND_SETUP1 && frame_number <= gpsp_pkg::KIND_SETUP5) begin
      frame_len = {2'b00, gpsp_pkg::setup_len(frame_number)};
    end else begin
      frame_len = query_len;
    end
  end

  assign got = rx_shift | (8'(s_axis_tdata[16]) << bit_position);

  always_comb begin
    configured_next    = configured;
    frame_number_next  = frame_number;
    byte_position_next = byte_position;
    bit_position_next  = bit_position;
    rx_shift_next      = rx_shift;
    active_next        = active;
    small_next         = small_motor_latch;
    large_next         = large_motor_latch;
    valid_o  = 1'b0;
    rx_o     = 8'h00;
    kind_o   = 3'd0;
    idx_o    = 5'd0;
    done_o   = 1'b0;
    status_o = 1'b0;
    if (s_axis_tuser == gpsp_pkg::REQ_START) begin
      small_next         = s_axis_tdata[7:0];
      large_next         = s_axis_tdata[15:8];
      frame_number_next  = gpsp_pkg::KIND_QUERY;
      byte_position_next = 5'd0;
      bit_position_next  = 3'd0;
      rx_shift_next      = 8'h00;
      active_next        = 1'b1;
    end else if (active) begin
      if (bit_position == 3'd7) begin
        valid_o           = 1'b1;
        rx_o              = got;
        kind_o            = frame_number;
        idx_o             = byte_position;
        rx_shift_next     = 8'h00;
        bit_position_next = 3'd0;
        priority if (byte_position == 5'd1 && got == gpsp_pkg::BYTE_NONE) begin
          // no device answering: abort the whole sequence
          if (frame_number == gpsp_pkg::KIND_QUERY) configured_next = 1'b0;
          active_next = 1'b0;
          done_o      = 1'b1;
          status_o    = 1'b1;
        end else if ({1'b0, byte_position} + 6'd1 >= frame_len) begin
          byte_position_next = 5'd0;
          priority if (frame_number == gpsp_pkg::KIND_QUERY && configured) begin
            active_next = 1'b0;
            done_o      = 1'b1;
          end else if (frame_number <= gpsp_pkg::KIND_SETUP4) begin
            frame_number_next = frame_number + 3'd1;
          end else if (frame_number == gpsp_pkg::KIND_SETUP5) begin
            configured_next   = 1'b1;
            frame_number_next = gpsp_pkg::KIND_REPEAT;
          end else begin
            active_next = 1'b0;
            done_o      = 1'b1;
          end
        end else begin
          byte_position_next = byte_position + 5'd1;
        end
      end else begin
        rx_shift_next     = got;
        bit_position_next = bit_position + 3'd1;
      end
    end
  end

  gpsp_cmd_rom u_rom (
    .kind        (frame_number_next),
    .pos         (byte_position_next),
    .small_motor (small_next),
    .large_motor (large_next),
    .cmd_byte    (cmd_byte)
  );

  assign cmd_o = active_next ? cmd_byte[bit_position_next] : 1'b1;

  always_comb begin
    res_data_next = {6'd0, status_o, done_o, idx_o, rx_o, valid_o, active_next, cmd_o};
    res_kind_next = kind_o;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_length       <= gpsp_pkg::POLL_LEN_RESET;
      configured        <= 1'b0;
      frame_number      <= 3'd0;
      byte_position     <= 5'd0;
      bit_position      <= 3'd0;
      rx_shift          <= 8'h00;
      active            <= 1'b0;
      small_motor_latch <= 8'h00;
      large_motor_latch <= 8'h00;
      res_valid         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) poll_length <= cfg_data;
      if (take) begin
        configured        <= configured_next;
        frame_number      <= frame_number_next;
        byte_position     <= byte_position_next;
        bit_position      <= bit_position_next;
        rx_shift          <= rx_shift_next;
        active            <= active_next;
        small_motor_latch <= small_next;
        large_motor_latch <= large_next;
        res_valid         <= 1'b1;
      end else if (m_axis_tready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_data <= res_data_next;
      res_kind <= res_kind_next;
    end
  end

`ifndef SYNTH
  a_done_drops_attention: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[16] |-> !m_axis_tdata[1])
    else $error("sequence end reported with attention still held");

  a_status_needs_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[17] |-> m_axis_tdata[16] && m_axis_tdata[2])
    else $error("failure status without end of sequence or byte");

  a_idle_bit_cleared: assert property (@(posedge clk) disable iff (rst)
    !active |-> bit_position == 3'd0)
    else $error("bit counter not cleared while idle");

  a_repeat_configured: assert property (@(posedge clk) disable iff (rst)
    frame_number == gpsp_pkg::KIND_REPEAT |-> configured)
    else $error("repeat query running while unconfigured");

  a_frame_range: assert property (@(posedge clk) disable iff (rst)
    frame_number != 3'd7)
    else $error("frame number out of range");
`endif

endmodule

FILE: tb/gamepad_serial_poll_with_config_tb.sv
// Self-checking testbench for the serial controller poll sequencer.
// Depends on gpsp_pkg and gamepad_serial_poll_with_config; checks every result against an
// in-bench model of the frame sequencer under random input bursts and output stalls.
module gamepad_serial_poll_with_config_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_POLL = 21;
  localparam int unsigned TARGET_ITEMS = 1750;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [2:0] NO_FAIL = 3'd7;

  // Command bytes of set-up frames 1..5, positions 0..8.
  localparam logic [7:0] SETUP_CMDS [1:5][0:8] = '{
    '{gpsp_pkg::CMD_START, gpsp_pkg::CMD_CONFIG, 8'h00, gpsp_pkg::CMD_START, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00},
    '{gpsp_pkg::CMD_START, gpsp_pkg::CMD_MODE, 8'h00, gpsp_pkg::CMD_START,
      gpsp_pkg::BYTE_MASK, 8'h00, 8'h00, 8'h00, 8'h00},
    '{gpsp_pkg::CMD_START, gpsp_pkg::CMD_MOTOR, 8'h00, 8'h00, gpsp_pkg::CMD_START,
      gpsp_pkg::BYTE_NONE, gpsp_pkg::BYTE_NONE, gpsp_pkg::BYTE_NONE, gpsp_pkg::BYTE_NONE},
    '{gpsp_pkg::CMD_START, gpsp_pkg::CMD_PRESS, 8'h00, gpsp_pkg::BYTE_NONE,
      gpsp_pkg::BYTE_NONE, gpsp_pkg::BYTE_MASK, 8'h00, 8'h00, 8'h00},
    '{gpsp_pkg::CMD_START, gpsp_pkg::CMD_CONFIG, 8'h00, 8'h00, gpsp_pkg::BYTE_NONE,
      gpsp_pkg::BYTE_NONE, gpsp_pkg::BYTE_NONE, gpsp_pkg::BYTE_NONE, 8'h00}
  };
  localparam logic [4:0] SETUP_BYTES [1:5] = '{5'd5, 5'd9, 5'd9, 5'd9, 5'd8};

  typedef struct packed {
    logic       req;
    logic [7:0] rumble_small;
    logic [7:0] rumble_large;
    logic       data_bit;
  } poll_req_t;

  typedef struct packed {
    logic       cmd_bit;
    logic       attention;
    logic       byte_valid;
    logic [7:0] rx_byte;
    logic [2:0] frame_kind;
    logic [4:0] byte_index;
    logic       done_res;
    logic       status;
  } poll_res_t;

  typedef struct {
    logic [4:0] poll_len;
    logic       configured;
    logic [2:0] frame;
    logic [4:0] byte_pos;
    logic [2:0] bit_pos;
    logic [7:0] rx_sr;
    logic       active;
    logic [7:0] small_m;
    logic [7:0] large_m;
  } poller_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;

  always #6 clk = ~clk;

  gamepad_serial_poll_with_config #(.MAX_POLL_BYTES(MAX_POLL)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  poller_t     model;       // tracks the DUT, advanced on accepted transactions
  poller_t     plan;        // advanced as stimulus is queued, steers the sequences
  poll_req_t   pending_reqs[$];
  poll_res_t   expected_res[$];
  poll_req_t   cur_req;
  int unsigned errors = 0;
  int unsigned stim_count = 0;
  int unsigned n_sent = 0, n_checked = 0, n_bytes = 0, n_setup_bytes = 0;
  int unsigned n_seq_ok = 0, n_seq_fail = 0;
  int unsigned burst_left = 0, gap_left = 0;
  int unsigned rx_left = 0, rx_mode = 0, hold_count = 0, idle_cycles = 0;
  logic        want_hold = 1'b0, hold_done = 1'b0;

  function automatic poller_t poller_reset();
    poller_t st;
    st.poll_len   = gpsp_pkg::POLL_LEN_RESET;
    st.configured = 1'b0;
    st.frame      = gpsp_pkg::KIND_QUERY;
    st.byte_pos   = '0;
    st.bit_pos    = '0;
    st.rx_sr      = '0;
    st.active     = 1'b0;
    st.small_m    = '0;
    st.large_m    = '0;
    return st;
  endfunction

  function automatic logic is_setup(logic [2:0] kind);
    return kind >= gpsp_pkg::KIND_SETUP1 && kind <= gpsp_pkg::KIND_SETUP5;
  endfunction

  function automatic logic [4:0] frame_bytes(poller_t st, logic [2:0] kind);
    if (is_setup(kind)) return SETUP_BYTES[kind];
    if (st.poll_len < 5'd2) return 5'd2;
    if (st.poll_len > MAX_POLL) return 5'(MAX_POLL);
    return st.poll_len;
  endfunction

  function automatic logic [7:0] frame_cmd(poller_t st, logic [2:0] kind, logic [4:0] pos);
    if (is_setup(kind)) return (pos < 5'd9) ? SETUP_CMDS[kind][pos] : 8'h00;
    case (pos)
      5'd0:    return gpsp_pkg::CMD_START;
      5'd1:    return gpsp_pkg::CMD_POLL;
      5'd3:    return st.small_m;
      5'd4:    return st.large_m;
      default: return 8'h00;
    endcase
  endfunction

  // One request through the sequencer; returns the result it produces.
  function automatic poll_res_t poll_step(inout poller_t st, input poll_req_t rq);
    poll_res_t  r;
    logic [7:0] got;
    logic [7:0] cb;
    r = '0;
    if (rq.req == gpsp_pkg::REQ_START) begin
      st.small_m  = rq.rumble_small;
      st.large_m  = rq.rumble_large;
      st.frame    = gpsp_pkg::KIND_QUERY;
      st.byte_pos = '0;
      st.bit_pos  = '0;
      st.rx_sr    = '0;
      st.active   = 1'b1;
    end else if (st.active) begin
      st.rx_sr = st.rx_sr | (8'(rq.data_bit) << st.bit_pos);
      if (st.bit_pos == 3'd7) begin
        got          = st.rx_sr;
        r.byte_valid = 1'b1;
        r.rx_byte    = got;
        r.frame_kind = st.frame;
        r.byte_index = st.byte_pos;
        st.rx_sr     = '0;
        st.bit_pos   = '0;
        if (st.byte_pos == 5'd1 && got == gpsp_pkg::BYTE_NONE) begin
          // no device answering: abort, a failed first query forgets the set-up
          if (st.frame == gpsp_pkg::KIND_QUERY) st.configured = 1'b0;
          st.active  = 1'b0;
          r.done_res = 1'b1;
          r.status   = 1'b1;
        end else if (({1'b0, st.byte_pos} + 6'd1) >= {1'b0, frame_bytes(st, st.frame)}) begin
          st.byte_pos = '0;
          if (st.frame == gpsp_pkg::KIND_QUERY && st.configured) begin
            st.active  = 1'b0;
            r.done_res = 1'b1;
          end else if (st.frame <= gpsp_pkg::KIND_SETUP4) begin
            st.frame = st.frame + 3'd1;
          end else if (st.frame == gpsp_pkg::KIND_SETUP5) begin
            st.configured = 1'b1;
            st.frame      = gpsp_pkg::KIND_REPEAT;
          end else begin
            st.active  = 1'b0;
            r.done_res = 1'b1;
          end
        end else begin
          st.byte_pos = st.byte_pos + 5'd1;
        end
      end else begin
        st.bit_pos = st.bit_pos + 3'd1;
      end
    end
    if (st.active) begin
      cb          = frame_cmd(st, st.frame, st.byte_pos);
      r.cmd_bit   = cb[st.bit_pos];
      r.attention = 1'b1;
    end else begin
      r.cmd_bit   = 1'b1;
      r.attention = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH result %0d: %s", $realtime, n_checked, what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // Queue one request; slots offered while the sequencer is idle do not count.
  task automatic push_req(input logic req, input logic [7:0] ms, input logic [7:0] ml,
                          input logic db);
    poll_req_t rq;
    poll_res_t unused;
    rq = '{req: req, rumble_small: ms, rumble_large: ml, data_bit: db};
    if (req == gpsp_pkg::REQ_START || plan.active) stim_count++;
    pending_reqs.push_back(rq);
    unused = poll_step(plan, rq);
  endtask

  task automatic push_start();
    push_req(gpsp_pkg::REQ_START, 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic push_idle_slots(input int unsigned n);
    repeat (n) push_req(gpsp_pkg::REQ_SLOT, 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // A well-formed poll sequence with random response bytes; byte 1 reads FF only in
  // the frame chosen to fail. A rare restart drops the sequence midway.
  task automatic run_sequence(input logic [2:0] fail_kind);
    logic [7:0] resp;
    resp = '0;
    push_start();
    while (plan.active) begin
      if ($urandom_range(0, 299) == 0) begin
        push_start();
      end else begin
        if (plan.bit_pos == 3'd0) begin
          resp = 8'($urandom);
          if (plan.byte_pos == 5'd1) begin
            if (plan.frame == fail_kind) resp = gpsp_pkg::BYTE_NONE;
            else if (resp == gpsp_pkg::BYTE_NONE) resp = 8'hFE;
          end
        end
        push_req(gpsp_pkg::REQ_SLOT, 8'($urandom), 8'($urandom), resp[plan.bit_pos]);
      end
    end
  endtask

  function automatic logic outstanding();
    return pending_reqs.size() != 0 || s_axis_tvalid || expected_res.size() != 0;
  endfunction

  task automatic wait_drained();
    while (outstanding()) @(posedge clk);
  endtask

  task automatic write_poll_length(input logic [4:0] len);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model.poll_len = len;
    plan.poll_len  = len;
  endtask

  // Driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_res.push_back(poll_step(model, cur_req));
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'b0, cur_req.data_bit, cur_req.rumble_large,
                            cur_req.rumble_small};
          s_axis_tuser  <= cur_req.req;
          if (burst_left == 0) burst_left = $urandom_range(1, 60);
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern switches between modes, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (want_hold && !hold_done) begin
      hold_count++;
      if (hold_count >= LONG_HOLD) hold_done = 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(1, 40);
      end
      rx_left--;
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 4) == 0);
        default: m_axis_tready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // Monitor: compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_res.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata=0x%06h", m_axis_tdata));
      end else begin
        poll_res_t want;
        want = expected_res.pop_front();
        check_field("cmd_bit",    8'(m_axis_tdata[0]),     8'(want.cmd_bit));
        check_field("attention",  8'(m_axis_tdata[1]),     8'(want.attention));
        check_field("byte_valid", 8'(m_axis_tdata[2]),     8'(want.byte_valid));
        check_field("rx_byte",    m_axis_tdata[10:3],      want.rx_byte);
        check_field("byte_index", 8'(m_axis_tdata[15:11]), 8'(want.byte_index));
        check_field("done_res",   8'(m_axis_tdata[16]),    8'(want.done_res));
        check_field("status",     8'(m_axis_tdata[17]),    8'(want.status));
        check_field("frame_kind", 8'(m_axis_tuser),        8'(want.frame_kind));
        if (want.byte_valid) n_bytes++;
        if (want.byte_valid && is_setup(want.frame_kind)) n_setup_bytes++;
        if (want.done_res && !want.status) n_seq_ok++;
        if (want.done_res && want.status) n_seq_fail++;
      end
      n_checked++;
    end
  end

  // Watchdog: too long without any transaction while work is outstanding.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready) || !outstanding())
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] timeout: no progress for %0d cycles", $realtime, idle_cycles);
        $display("gamepad_serial_poll_with_config_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [4:0]  len;
    logic [2:0]  fail_kind;
    int unsigned phase, pick;
    model = poller_reset();
    plan  = poller_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle slots, extreme motor bytes, restart while busy, no-device abort.
    push_idle_slots(1);
    push_req(gpsp_pkg::REQ_SLOT, 8'hFF, 8'hFF, 1'b1);
    push_req(gpsp_pkg::REQ_START, 8'hFF, 8'hFF, 1'b0);
    for (int i = 0; i < 5; i++) push_req(gpsp_pkg::REQ_SLOT, 8'h00, 8'h00, 1'(i));
    push_req(gpsp_pkg::REQ_START, 8'h00, 8'h00, 1'b1);
    for (int i = 0; i < 8; i++) push_req(gpsp_pkg::REQ_SLOT, 8'hFF, 8'h00, 1'(8'hA5 >> i));
    for (int i = 0; i < 8; i++)
      push_req(gpsp_pkg::REQ_SLOT, 8'h00, 8'hFF, gpsp_pkg::BYTE_NONE[i]);
    push_req(gpsp_pkg::REQ_SLOT, 8'h5A, 8'hA5, 1'b0);

    phase = 0;
    while (stim_count < TARGET_ITEMS) begin
      case (phase)
        0: len = 5'd2;
        1: len = 5'd31;
        2: len = 5'd0;
        3: len = 5'd1;
        4: len = 5'(MAX_POLL);
        default: begin
          pick = $urandom_range(0, 9);
          if (pick < 7)       len = 5'($urandom_range(2, 6));
          else if (pick == 7) len = 5'($urandom_range(0, 31));
          else if (pick == 8) len = 5'(MAX_POLL);
          else                len = 5'($urandom_range(7, 20));
        end
      endcase
      write_poll_length(len);
      repeat ((phase < 5) ? 1 : $urandom_range(1, 3)) begin
        pick = $urandom_range(0, 9);
        if (phase < 2)      fail_kind = NO_FAIL;
        else if (pick < 3)  fail_kind = gpsp_pkg::KIND_QUERY;
        else if (pick == 3)
          fail_kind = 3'($urandom_range(gpsp_pkg::KIND_SETUP1, gpsp_pkg::KIND_SETUP5));
        else if (pick == 4) fail_kind = gpsp_pkg::KIND_REPEAT;
        else                fail_kind = NO_FAIL;
        run_sequence(fail_kind);
        if ($urandom_range(0, 2) == 0) push_idle_slots($urandom_range(1, 3));
      end
      // configured long query: let the output back up and stall the input
      if (phase == 1) want_hold = 1'b1;
      phase++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_res.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_res.size()));
    $display("Run: %0d requests, %0d results checked, %0d config phases.",
             n_sent, n_checked, phase);
    $display("Bytes: %0d received (%0d in set-up frames); sequences: %0d ok, %0d failed.",
             n_bytes, n_setup_bytes, n_seq_ok, n_seq_fail);
    if (errors == 0) begin
      $display("gamepad_serial_poll_with_config_tb: PASS");
    end else begin
      $display("gamepad_serial_poll_with_config_tb: FAIL");
    end
    $finish;
  end

endmodule
